[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of the heap queue.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

[rtl/core/bmhq_pkg.sv]
// Package for the binary max-heap queue: sizes, operation and status codes,
// and the result word passed from the sequencer to the output stage. No dependencies.
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int DEPTH   = 64;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  popped;
        logic signed [VALUE_W-1:0]  top;
        logic                       no_entries;
        logic [CNT_W-1:0]           entries;
    } res_t;

endpackage

[rtl/core/bmhq_cmp.sv]
// Shared signed greater-than comparator used by every sift step.
// Depends on bmhq_pkg for the value width.
`timescale 1ns / 1ps

module bmhq_cmp
    import bmhq_pkg::*;
(
    input  logic signed [VALUE_W-1:0] a,
    input  logic signed [VALUE_W-1:0] b,
    output logic                      a_gt_b
);

    assign a_gt_b = (a > b);

endmodule

[rtl/core/bmhq_ctrl.sv]
// Sequencer of the heap queue: holds the heap memory, the entry count and a
// copy of the root, and walks sift-up and sift-down with one shared comparator.
// Depends on bmhq_pkg and bmhq_cmp.
`timescale 1ns / 1ps

module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      res_valid,
    input  logic                      res_ready,
    output res_t                      res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_UP_WR,
        ST_DN_LOAD,
        ST_DN_RD,
        ST_DN_SEL,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    logic signed [VALUE_W-1:0] mem [DEPTH];

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] child_val_reg, child_val_next;
    logic [ADDR_W-1:0]         child_idx_reg, child_idx_next;
    logic signed [VALUE_W-1:0] top_reg, top_next;
    status_t                   status_reg, status_next;
    logic signed [VALUE_W-1:0] popped_reg, popped_next;
    logic signed [VALUE_W-1:0] rd_a_reg, rd_b_reg;

    logic [ADDR_W-1:0]         addr_a, addr_b;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic signed [VALUE_W-1:0] cmp_a, cmp_b;
    logic                      cmp_gt;

    logic [ADDR_W-1:0]         parent;
    logic [ADDR_W:0]           left_w, right_w;
    logic [ADDR_W-1:0]         push_slot;

    bmhq_cmp u_cmp (
        .a      (cmp_a),
        .b      (cmp_b),
        .a_gt_b (cmp_gt)
    );

    assign parent    = idx_reg >> 1;
    assign left_w    = {idx_reg, 1'b0};
    assign right_w   = {idx_reg, 1'b1};
    assign push_slot = ADDR_W'(count_reg + CNT_W'(1));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        child_val_next = child_val_reg;
        child_idx_next = child_idx_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        addr_a         = idx_reg;
        addr_b         = idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = val_reg;
        cmp_a          = val_reg;
        cmp_b          = rd_a_reg;
        s_ready        = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    popped_next = '0;
                    status_next = STAT_DONE;
                    if (s_func == FUNC_PUSH) begin
                        if (count_reg >= CNT_W'(DEPTH - 1)) begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                            idx_next   = push_slot;
                            val_next   = s_value;
                            if (count_reg == '0) begin
                                mem_we     = 1'b1;
                                mem_waddr  = ADDR_W'(1);
                                mem_wdata  = s_value;
                                state_next = ST_DONE;
                            end else begin
                                addr_a     = push_slot >> 1;
                                state_next = ST_UP_CMP;
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_DONE;
                        end else begin
                            // The root copy is the value being removed.
                            popped_next = top_reg;
                            count_next  = count_reg - CNT_W'(1);
                            idx_next    = ADDR_W'(1);
                            addr_a      = ADDR_W'(count_reg);
                            if (count_reg == CNT_W'(1)) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_DN_LOAD;
                            end
                        end
                    end
                end
            end

            ST_UP_CMP: begin
                // The new word rides in val_reg; a smaller parent moves down into the hole.
                cmp_a = val_reg;
                cmp_b = rd_a_reg;
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (cmp_gt) begin
                    mem_wdata = rd_a_reg;
                    idx_next  = parent;
                    if (parent == ADDR_W'(1)) begin
                        state_next = ST_UP_WR;
                    end else begin
                        addr_a = parent >> 1;
                    end
                end else begin
                    mem_wdata  = val_reg;
                    state_next = ST_DONE;
                end
            end

            ST_UP_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = val_reg;
                state_next = ST_DONE;
            end

            ST_DN_LOAD: begin
                val_next   = rd_a_reg;
                state_next = ST_DN_RD;
            end

            ST_DN_RD: begin
                if (left_w <= {1'b0, count_reg}) begin
                    addr_a     = left_w[ADDR_W-1:0];
                    addr_b     = right_w[ADDR_W-1:0];
                    state_next = ST_DN_SEL;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg;
                    mem_wdata  = val_reg;
                    state_next = ST_DONE;
                end
            end

            ST_DN_SEL: begin
                // The right child is taken only when it exists and is strictly larger.
                cmp_a = rd_b_reg;
                cmp_b = rd_a_reg;
                if ((right_w <= {1'b0, count_reg}) && cmp_gt) begin
                    child_val_next = rd_b_reg;
                    child_idx_next = right_w[ADDR_W-1:0];
                end else begin
                    child_val_next = rd_a_reg;
                    child_idx_next = left_w[ADDR_W-1:0];
                end
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP: begin
                cmp_a     = child_val_reg;
                cmp_b     = val_reg;
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (cmp_gt) begin
                    mem_wdata  = child_val_reg;
                    idx_next   = child_idx_reg;
                    state_next = ST_DN_RD;
                end else begin
                    mem_wdata  = val_reg;
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Keep a copy of slot 1 so that pops and results need no extra read.
    always_comb begin
        top_next = top_reg;
        if (mem_we && (mem_waddr == ADDR_W'(1))) begin
            top_next = mem_wdata;
        end
    end

    assign res.status     = status_reg;
    assign res.popped     = popped_reg;
    assign res.top        = (count_reg == '0) ? '0 : top_reg;
    assign res.no_entries = (count_reg == '0);
    assign res.entries    = count_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        child_val_reg <= child_val_next;
        child_idx_reg <= child_idx_next;
        top_reg       <= top_next;
        status_reg    <= status_next;
        popped_reg    <= popped_next;
    end

endmodule

[rtl/core/binary_max_heap_queue.sv]
// Binary max-heap queue. One word is taken at a time. A rejected word, a push into an empty
// heap or a pop of the last entry goes straight to its result word; a push climbs one level
// per compare-and-write step, and any other pop loads the last entry, then per level reads
// the children, selects the larger and compares it until a leaf or a compare stops it.
// The next word is taken the cycle after the result enters the output register.
// Synchronous active-low reset empties the queue; heap memory contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_max_heap_queue
    import bmhq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [VALUE_W-1:0] m_popped,
    output logic signed [VALUE_W-1:0] m_top,
    output logic                      m_is_empty_now,
    output logic [CNT_W-1:0]          m_entries
);

    logic res_valid;
    logic res_ready;
    res_t res;

    logic m_valid_reg, m_valid_next;
    res_t out_reg, out_next;

    logic rejected_full;
    logic rejected_empty;

    bmhq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_value   (s_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_reg.status;
    assign m_popped       = out_reg.popped;
    assign m_top          = out_reg.top;
    assign m_is_empty_now = out_reg.no_entries;
    assign m_entries      = out_reg.entries;

    assign rejected_full  = m_valid && (m_status == STAT_FULL);
    assign rejected_empty = m_valid && (m_status == STAT_EMPTY);

    `ASSERT_IMPLY(a_empty_flag, aclk, aresetn, m_valid, m_is_empty_now == (m_entries == '0))
    `ASSERT_IMPLY(a_full_count, aclk, aresetn, rejected_full, m_entries == CNT_W'(DEPTH - 1))
    `ASSERT_IMPLY(a_empty_pop, aclk, aresetn, rejected_empty, (m_entries == '0) && (m_popped == '0))
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

[verif/binary_max_heap_queue_test.sv]
// Self-checking testbench for the binary max-heap queue: a bursty driver, a stalling
// monitor and an in-line heap predictor compare every result word field by field.
// Depends on bmhq_pkg and the binary_max_heap_queue RTL.
`timescale 1ns / 1ps

module binary_max_heap_queue_test;
    import bmhq_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_WORDS = 550;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
    } heap_req_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_func = FUNC_PUSH;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [1:0]                m_status;
    logic signed [VALUE_W-1:0] m_popped;
    logic signed [VALUE_W-1:0] m_top;
    logic                      m_is_empty_now;
    logic [CNT_W-1:0]          m_entries;

    // Requests waiting to be driven and results predicted but not yet seen.
    heap_req_t pending_reqs[$];
    res_t      expected_results[$];

    // Predictor state: a heap of its own, slots 1 to DEPTH-1.
    logic signed [VALUE_W-1:0] heap_model[DEPTH];
    int                        model_count = 0;

    int        mismatches = 0;
    int        results_seen = 0;
    int        cycles = 0;
    int        tx_burst = 1;
    int        tx_gap = 0;
    int        rx_hold = 0;
    logic      rx_open = 1'b0;
    heap_req_t next_req;
    res_t      want_res;

    binary_max_heap_queue u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_popped       (m_popped),
        .m_top          (m_top),
        .m_is_empty_now (m_is_empty_now),
        .m_entries      (m_entries)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic queue_req(input logic func, input logic signed [VALUE_W-1:0] value);
        heap_req_t r;
        r.func  = func;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    // Applies one request to the model heap and records the result word it should give.
    task automatic predict_heap_result(input logic func,
                                       input logic signed [VALUE_W-1:0] value);
        res_t                      r;
        int                        slot;
        int                        kid;
        logic                      settled;
        logic signed [VALUE_W-1:0] tmp;
        r = '0;
        r.status = STAT_DONE;
        if (func == FUNC_PUSH) begin
            if (model_count >= DEPTH - 1) begin
                r.status = STAT_FULL;
            end else begin
                model_count++;
                slot = model_count;
                heap_model[slot] = value;
                while (slot > 1 && heap_model[slot] > heap_model[slot / 2]) begin
                    tmp = heap_model[slot / 2];
                    heap_model[slot / 2] = heap_model[slot];
                    heap_model[slot] = tmp;
                    slot = slot / 2;
                end
            end
        end else begin
            if (model_count == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.popped = heap_model[1];
                heap_model[1] = heap_model[model_count];
                model_count--;
                slot = 1;
                settled = 1'b0;
                while (!settled && 2 * slot <= model_count) begin
                    kid = 2 * slot;
                    // On equal children the left one is kept.
                    if (kid + 1 <= model_count && heap_model[kid + 1] > heap_model[kid]) begin
                        kid++;
                    end
                    if (heap_model[kid] > heap_model[slot]) begin
                        tmp = heap_model[kid];
                        heap_model[kid] = heap_model[slot];
                        heap_model[slot] = tmp;
                        slot = kid;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
        end
        r.top        = (model_count > 0) ? heap_model[1] : '0;
        r.no_entries = (model_count == 0);
        r.entries    = model_count[CNT_W-1:0];
        expected_results.push_back(r);
    endtask

    // Mostly full-range values, with a narrow band to force ties and a share of extremes.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $signed($urandom_range(0, 8)) - 4;
            3: begin
                case ($urandom_range(0, 3))
                    0: v = {1'b0, {(VALUE_W - 1){1'b1}}};
                    1: v = {1'b1, {(VALUE_W - 1){1'b0}}};
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Driver: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_heap_result(s_func, s_value);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0 || pending_reqs.size() == 0) begin
                    if (tx_gap > 0) begin
                        tx_gap--;
                    end
                    s_valid <= 1'b0;
                end else begin
                    next_req = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_func  <= next_req.func;
                    s_value <= next_req.value;
                    if (tx_burst <= 1) begin
                        tx_burst = $urandom_range(1, 12);
                        tx_gap   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
                    end else begin
                        tx_burst--;
                    end
                end
            end
        end
    end

    // Monitor: checks each accepted result word and stalls on alternating open and shut spells.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want_res = expected_results.pop_front();
                    if (m_status !== want_res.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  results_seen, m_status, want_res.status));
                    if (m_popped !== want_res.popped)
                        report_mismatch($sformatf("result %0d popped %0d, expected %0d",
                                                  results_seen, m_popped, want_res.popped));
                    if (m_top !== want_res.top)
                        report_mismatch($sformatf("result %0d top %0d, expected %0d",
                                                  results_seen, m_top, want_res.top));
                    if (m_is_empty_now !== want_res.no_entries)
                        report_mismatch($sformatf("result %0d is_empty_now %0b, expected %0b",
                                                  results_seen, m_is_empty_now,
                                                  want_res.no_entries));
                    if (m_entries !== want_res.entries)
                        report_mismatch($sformatf("result %0d entries %0d, expected %0d",
                                                  results_seen, m_entries, want_res.entries));
                end
                results_seen++;
            end
            if (rx_hold == 0) begin
                rx_open = !rx_open;
                if (rx_open)
                    rx_hold = $urandom_range(1, 40);
                else
                    rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25)
                                                          : $urandom_range(1, 3);
            end
            rx_hold--;
            m_ready <= rx_open;
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("binary_max_heap_queue verification failed");
        $finish;
    end

    initial begin
        int k;
        int span;
        int push_pct;
        int n_random;
        int n_phase;
        n_random = 0;
        n_phase  = 0;

        // Directed: empty pops, the last entry leaving, extremes and ties at the root.
        queue_req(FUNC_POP, 32'h1234_5678);
        queue_req(FUNC_PUSH, '0);
        queue_req(FUNC_POP, '1);
        queue_req(FUNC_POP, '0);
        queue_req(FUNC_PUSH, {1'b0, {(VALUE_W - 1){1'b1}}});
        queue_req(FUNC_PUSH, {1'b1, {(VALUE_W - 1){1'b0}}});
        queue_req(FUNC_PUSH, '1);
        queue_req(FUNC_PUSH, 1);
        queue_req(FUNC_PUSH, 5);
        queue_req(FUNC_PUSH, 5);
        queue_req(FUNC_PUSH, 5);
        queue_req(FUNC_PUSH, {1'b0, {(VALUE_W - 1){1'b1}}});
        for (k = 0; k < 9; k++) begin
            queue_req(FUNC_POP, $urandom);
        end

        // Random: fill, mixed, drain and mixed spells in turn, so that the heap keeps
        // reaching both full and empty.
        while (n_random < RANDOM_WORDS) begin
            case (n_phase % 4)
                0: begin push_pct = 95; span = $urandom_range(70, 110); end
                1: begin push_pct = 50; span = $urandom_range(30, 70); end
                2: begin push_pct = 5;  span = $urandom_range(70, 110); end
                default: begin push_pct = 65; span = $urandom_range(30, 70); end
            endcase
            for (k = 0; k < span && n_random < RANDOM_WORDS; k++) begin
                queue_req(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP,
                          pick_value());
                n_random++;
            end
            n_phase++;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0) begin
            @(posedge aclk);
        end
        // Extra drain cycles catch any stray word after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() > 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end
        if (mismatches == 0) begin
            $display("binary_max_heap_queue verification clean");
        end else begin
            $display("binary_max_heap_queue verification failed");
        end
        $finish;
    end

endmodule
